/* hdl/eml_pkg.sv */
package eml_pkg;

    localparam int DEF_MAX_SLOTS = 256;

    localparam int FLAGS_W  = 8;
    localparam int OFFSET_W = 40;
    localparam int LENGTH_W = 24;
    localparam int ADDR_W   = 40;
    localparam int DISK_W   = 41;
    localparam int SLOT_W   = 8;
    localparam int CFG_W    = 16;
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 3;

    localparam logic [CFG_W-1:0] NEXT_SLOT_RST = 16'd2;
    localparam logic [CFG_W-1:0] MAX_SLOTS_RST = 16'd256;
    localparam logic [CFG_W-1:0] FIRST_SLOT    = 16'd2;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef enum logic [0:0] {
        REG_NEXT_SLOT = 1'b0,
        REG_MAX_SLOTS = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_FOUND      = 2'd0,
        ST_NOT_FOUND  = 2'd1,
        ST_BAD_HEADER = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [FLAGS_W-1:0]  flags;
        logic [OFFSET_W-1:0] offset;
        logic [LENGTH_W-1:0] length;
        logic [ADDR_W-1:0]   address;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // controller -> datapath
    typedef struct packed {
        logic wr_en;
        logic start;
        logic run;
        logic load;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hdr_bad;
        logic hit;
        logic miss;
        logic exhausted;
        logic out_free;
    } t_dp_sts;

endpackage

/* hdl/eml_ram.sv */
module eml_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/eml_ctrl.sv */
module eml_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_cmd,
    input  eml_pkg::t_dp_sts i_sts,
    output logic             o_in_ready,
    output eml_pkg::t_dp_cmd o_dp_cmd
);
    import eml_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_dp_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_cmd == CMD_WRITE) begin
                        o_dp_cmd.wr_en = 1'b1;
                    end else begin
                        o_dp_cmd.start = 1'b1;
                        n_state = i_sts.hdr_bad ? S_DONE : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_dp_cmd.run = 1'b1;
                if (i_sts.hit || i_sts.miss || i_sts.exhausted) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // wait for the result register to drain
                if (i_sts.out_free) begin
                    o_dp_cmd.load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* hdl/eml_dp.sv */
module eml_dp #(
    parameter int MAX_SLOTS = eml_pkg::DEF_MAX_SLOTS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  eml_pkg::t_dp_cmd               i_dp_cmd,
    output eml_pkg::t_dp_sts               o_sts,
    input  logic [eml_pkg::CFG_W-1:0]      i_next_slot,
    input  logic [eml_pkg::CFG_W-1:0]      i_max_slots,
    input  logic [eml_pkg::SLOT_W-1:0]     i_slot,
    input  logic [eml_pkg::FLAGS_W-1:0]    i_new_flags,
    input  logic [eml_pkg::OFFSET_W-1:0]   i_new_offset,
    input  logic [eml_pkg::LENGTH_W-1:0]   i_new_length,
    input  logic [eml_pkg::ADDR_W-1:0]     i_new_address,
    input  logic [eml_pkg::OFFSET_W-1:0]   i_query_block,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_status,
    output logic [eml_pkg::FLAGS_W-1:0]    o_ext_flags,
    output logic [eml_pkg::OFFSET_W-1:0]   o_ext_start,
    output logic [eml_pkg::DISK_W-1:0]     o_phys_block,
    output logic [eml_pkg::LENGTH_W-1:0]   o_run_length
);
    import eml_pkg::*;

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int CW = IW + 1;

    // scan pointer and lookup key
    logic [CW-1:0]       r_cnt;
    logic                r_pend;
    logic [OFFSET_W-1:0] r_fb;
    t_status             r_kind;

    // captured hit
    t_entry              r_hit;
    logic [OFFSET_W-1:0] r_dist;

    // result register
    logic                r_ovalid;
    t_status             r_status;
    logic [FLAGS_W-1:0]  r_flags;
    logic [OFFSET_W-1:0] r_start;
    logic [DISK_W-1:0]   r_disk;
    logic [LENGTH_W-1:0] r_run;

    logic                slot_ok;
    logic                wr_en;
    t_entry              wr_entry;
    t_entry              rd_entry;
    logic [ENTRY_W-1:0]  rd_data;
    logic                more;
    logic                nz;
    logic                below_off;
    logic [OFFSET_W-1:0] gap;
    logic                covers;

    assign slot_ok  = {1'b0, i_slot} < 9'(MAX_SLOTS);
    assign wr_en    = i_dp_cmd.wr_en && slot_ok;
    assign wr_entry = '{flags: i_new_flags, offset: i_new_offset,
                        length: i_new_length, address: i_new_address};

    eml_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (i_slot[IW-1:0]),
        .i_wdata (wr_entry),
        .i_raddr (r_cnt[IW-1:0]),
        .o_rdata (rd_data)
    );

    assign rd_entry = t_entry'(rd_data);

    assign more      = CFG_W'(r_cnt) < i_next_slot;
    assign nz        = rd_entry.length != '0;
    assign below_off = r_fb < rd_entry.offset;
    assign gap       = r_fb - rd_entry.offset;
    assign covers    = gap < OFFSET_W'(rd_entry.length);

    assign o_sts.hdr_bad   = (i_next_slot < FIRST_SLOT) || (i_max_slots < i_next_slot) ||
                             (i_max_slots > CFG_W'(MAX_SLOTS));
    assign o_sts.hit       = r_pend && nz && !below_off && covers;
    assign o_sts.miss      = r_pend && nz && below_off;
    assign o_sts.exhausted = !r_pend && !more;
    assign o_sts.out_free  = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (i_dp_cmd.start) begin
            r_pend <= 1'b0;
        end else if (i_dp_cmd.run) begin
            r_pend <= more;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.start) begin
            r_cnt  <= CW'(FIRST_SLOT);
            r_fb   <= i_query_block;
            r_kind <= o_sts.hdr_bad ? ST_BAD_HEADER : ST_NOT_FOUND;
        end else if (i_dp_cmd.run) begin
            if (more) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (o_sts.hit) begin
                r_kind <= ST_FOUND;
                r_hit  <= rd_entry;
                r_dist <= gap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_dp_cmd.load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_status <= r_kind;
            if (r_kind == ST_FOUND) begin
                r_flags <= r_hit.flags;
                r_start <= r_hit.offset;
                r_disk  <= {1'b0, r_hit.address} + {1'b0, r_dist};
                // distance is below the length here, so it fits the length width
                r_run   <= r_hit.length - r_dist[LENGTH_W-1:0];
            end else begin
                r_flags <= '0;
                r_start <= '0;
                r_disk  <= '0;
                r_run   <= '0;
            end
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_status     = r_status;
    assign o_ext_flags  = r_flags;
    assign o_ext_start  = r_start;
    assign o_phys_block = r_disk;
    assign o_run_length = r_run;

endmodule

/* hdl/extent_map_lookup_top.sv */
// channel   | handshake                    | payload
// ----------+------------------------------+-------------------------------------------
// input     | i_in_valid / o_in_ready      | i_cmd i_slot i_new_* i_query_block
// output    | o_out_valid / i_out_ready    | o_status o_ext_flags o_ext_start
//           |                              | o_phys_block o_run_length
// config    | psel penable pwrite pready   | paddr pwdata prdata
//
// A write item gives no result.
// A lookup scans the slots from 2 up to next_slot - 1 and ends at the first hit, a miss or
// the end of the table; a bad header skips the scan.
// The descriptor RAM has one registered read port and the scan reads one slot per cycle.
// Reset clears the controller, the result valid flag and the header registers (2 and 256);
// the descriptor RAM is not cleared.
// A waiting result does not block write items; a finished lookup holds until it is taken.
module extent_map_lookup_top #(
    parameter int MAX_SLOTS = eml_pkg::DEF_MAX_SLOTS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_cmd,
    input  logic [eml_pkg::SLOT_W-1:0]     i_slot,
    input  logic [eml_pkg::FLAGS_W-1:0]    i_new_flags,
    input  logic [eml_pkg::OFFSET_W-1:0]   i_new_offset,
    input  logic [eml_pkg::LENGTH_W-1:0]   i_new_length,
    input  logic [eml_pkg::ADDR_W-1:0]     i_new_address,
    input  logic [eml_pkg::OFFSET_W-1:0]   i_query_block,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_status,
    output logic [eml_pkg::FLAGS_W-1:0]    o_ext_flags,
    output logic [eml_pkg::OFFSET_W-1:0]   o_ext_start,
    output logic [eml_pkg::DISK_W-1:0]     o_phys_block,
    output logic [eml_pkg::LENGTH_W-1:0]   o_run_length,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [eml_pkg::PADDR_W-1:0]    paddr,
    input  logic [eml_pkg::PDATA_W-1:0]    pwdata,
    output logic [eml_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);
    import eml_pkg::*;

    logic [CFG_W-1:0] r_next_slot;
    logic [CFG_W-1:0] r_max_slots;
    t_reg_idx         reg_idx;
    logic             cfg_wr;
    t_dp_cmd          dp_cmd;
    t_dp_sts          dp_sts;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_slot <= NEXT_SLOT_RST;
            r_max_slots <= MAX_SLOTS_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_NEXT_SLOT: r_next_slot <= pwdata[CFG_W-1:0];
                REG_MAX_SLOTS: r_max_slots <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_NEXT_SLOT: prdata = PDATA_W'(r_next_slot);
            REG_MAX_SLOTS: prdata = PDATA_W'(r_max_slots);
            default:       prdata = '0;
        endcase
    end

    eml_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_sts      (dp_sts),
        .o_in_ready (o_in_ready),
        .o_dp_cmd   (dp_cmd)
    );

    eml_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dp_cmd      (dp_cmd),
        .o_sts         (dp_sts),
        .i_next_slot   (r_next_slot),
        .i_max_slots   (r_max_slots),
        .i_slot        (i_slot),
        .i_new_flags   (i_new_flags),
        .i_new_offset  (i_new_offset),
        .i_new_length  (i_new_length),
        .i_new_address (i_new_address),
        .i_query_block (i_query_block),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_ext_flags   (o_ext_flags),
        .o_ext_start   (o_ext_start),
        .o_phys_block  (o_phys_block),
        .o_run_length  (o_run_length)
    );

endmodule

/* hdl/eml_chk.sv */
module eml_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           i_cmd,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [1:0]                     o_status,
    input logic [eml_pkg::FLAGS_W-1:0]    o_ext_flags,
    input logic [eml_pkg::OFFSET_W-1:0]   o_ext_start,
    input logic [eml_pkg::DISK_W-1:0]     o_phys_block,
    input logic [eml_pkg::LENGTH_W-1:0]   o_run_length
);
    import eml_pkg::*;

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_phys_block))
        else $error("result changed while stalled");

    // an accepted lookup leaves the input not ready right after it is taken
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_cmd == CMD_LOOKUP |=> !o_in_ready)
        else $error("input taken right after a lookup");

    // a miss or bad header carries an empty payload
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_FOUND |-> o_ext_flags == '0 && o_ext_start == '0
            && o_phys_block == '0 && o_run_length == '0)
        else $error("non-hit result with payload");

    // a hit always leaves at least one block in the run
    a_hit_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FOUND |-> o_run_length != '0)
        else $error("hit with empty run");

endmodule

bind extent_map_lookup_top eml_chk u_eml_chk (.*);
